/* hw/rtl/panel_switch_qualifier_top_assert.svh */
// Assertion macros for the panel switch qualifier checker.
`ifndef PANEL_SWITCH_QUALIFIER_TOP_ASSERT_SVH
`define PANEL_SWITCH_QUALIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PSQ_ASSERT_NOW(lbl, ck, rstn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (a) |-> (c)) \
    else $error("psq assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PSQ_ASSERT_NEXT(lbl, ck, rstn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (a) |=> (c)) \
    else $error("psq assertion failed");

// Next-cycle implication that is checked through reset as well.
`define PSQ_ASSERT_RST(lbl, ck, a, c) \
  lbl: assert property (@(posedge ck) (a) |=> (c)) \
    else $error("psq reset assertion failed");

`endif

/* hw/rtl/psq_pkg.sv */
// Package: widths, pin positions and word constants of the panel switch qualifier.
package psq_pkg;

  localparam int PIN_COUNT = 29;
  localparam int SAMPLE_W  = 29;
  localparam int STEADY_W  = 16;
  localparam int ACTION_W  = 13;
  localparam int PAIR_N    = 6;

  // Inputs at or above the pin count are masked off.
  localparam logic [SAMPLE_W-1:0] PIN_MASK =
    SAMPLE_W'((64'd1 << PIN_COUNT) - 64'd1);

  localparam logic [STEADY_W-1:0] STEADY_IDLE = 16'h2aa8;
  localparam int STOP_FLAG = 15;
  localparam int LEARN_BIT = 14;
  localparam int AUTO_BIT  = 1;
  localparam int EN_BIT    = 0;
  localparam int BELL_BIT  = 12;

  localparam int IN_EN    = 0;
  localparam int IN_AUTO  = 1;
  localparam int IN_STOP  = 26;
  localparam int IN_LEARN = 27;
  localparam int IN_BELL  = 28;

  typedef logic [4:0] pin_idx_t;
  typedef pin_idx_t [PAIR_N-1:0] pin_list_t;

  // Start inputs of the start/stop pairs; stop is the next input up.
  localparam pin_list_t PAIR_IN = '{5'd20, 5'd10, 5'd8, 5'd6, 5'd4, 5'd2};
  // First inputs of the direction pairs; the second is the next input up.
  localparam pin_list_t DIR_IN  = '{5'd24, 5'd22, 5'd18, 5'd16, 5'd14, 5'd12};

  typedef struct packed {
    logic [STEADY_W-1:0] steady;
    logic [ACTION_W-1:0] action;
  } psq_words_t;

endpackage

/* hw/rtl/psq_rules.sv */
// Qualification rules: next stored sample and next words for one scan item.
module psq_rules (
  input  logic [psq_pkg::SAMPLE_W-1:0] sample,
  input  logic [psq_pkg::SAMPLE_W-1:0] last_sample,
  input  psq_pkg::psq_words_t          words,
  output logic [psq_pkg::SAMPLE_W-1:0] last_sample_nxt,
  output psq_pkg::psq_words_t          words_nxt
);
  import psq_pkg::*;

  logic [SAMPLE_W-1:0] s;
  logic [STEADY_W-1:0] st;
  logic [ACTION_W-1:0] ac;

  assign s = sample & PIN_MASK;

  always_comb begin
    st = words.steady;
    st[STOP_FLAG] = 1'b0;
    st[EN_BIT]    = 1'b1;
    st[AUTO_BIT]  = s[IN_AUTO];
    st[LEARN_BIT] = ~s[IN_AUTO] & s[IN_LEARN];
    ac = '0;
    for (int k = 0; k < PAIR_N; k++) begin
      // start wins, then stop, else hold
      if (s[PAIR_IN[k]]) begin
        st[2*k+2] = 1'b1;
        st[2*k+3] = 1'b0;
      end else if (s[PAIR_IN[k] + 5'd1]) begin
        st[2*k+2] = 1'b0;
        st[2*k+3] = 1'b1;
      end
      ac[2*k]   = s[DIR_IN[k]];
      ac[2*k+1] = ~s[DIR_IN[k]] & s[DIR_IN[k] + 5'd1];
    end
    ac[BELL_BIT] = s[IN_BELL];
  end

  always_comb begin
    last_sample_nxt = s;
    words_nxt       = words;
    if (s == last_sample) begin
      if (!s[IN_STOP]) begin
        words_nxt.steady = STEADY_IDLE | (STEADY_W'(1) << STOP_FLAG);
        words_nxt.action = '0;
      end else if (!s[IN_EN]) begin
        words_nxt.steady = STEADY_IDLE;
        words_nxt.action = '0;
      end else begin
        words_nxt.steady = st;
        words_nxt.action = ac;
      end
    end
  end

endmodule

/* hw/rtl/psq_state_reg.sv */
// State registers: last sample and the two words, loaded on each accepted item.
module psq_state_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [psq_pkg::SAMPLE_W-1:0] last_sample_nxt,
  input  psq_pkg::psq_words_t          words_nxt,
  output logic [psq_pkg::SAMPLE_W-1:0] last_sample,
  output psq_pkg::psq_words_t          words
);
  import psq_pkg::*;

  logic [SAMPLE_W-1:0] last_sample_r;
  psq_words_t          words_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r  <= '0;
      words_r.steady <= STEADY_IDLE;
      words_r.action <= '0;
    end else if (load) begin
      last_sample_r <= last_sample_nxt;
      words_r       <= words_nxt;
    end
  end

  assign last_sample = last_sample_r;
  assign words       = words_r;

endmodule

/* hw/rtl/panel_switch_qualifier_top.sv */
// Top level of the panel switch qualifier: handshakes, rules and state registers.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_pin_sample[28:0]
//   out_     out  out_valid/out_ready  out_steady_word[15:0], out_action_word[12:0]
//
// The result of an item is on the out_ ports in the cycle after it is taken.
// One item per cycle while out_ready is high; the compare and bit rules are
// combinational, worked out in one pass from the state registers and the sample.
// The state registers double as the result register, so a new item is taken
// whenever no result waits or the waiting one is taken in the same cycle.
// Reset (synchronous, rst_n low): last sample 0, steady word 0x2aa8, action 0,
// no result pending.
module panel_switch_qualifier_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [psq_pkg::SAMPLE_W-1:0] in_pin_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psq_pkg::STEADY_W-1:0] out_steady_word,
  output logic [psq_pkg::ACTION_W-1:0] out_action_word
);
  import psq_pkg::*;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                in_take;
  logic [SAMPLE_W-1:0] last_sample;
  logic [SAMPLE_W-1:0] last_sample_nxt;
  psq_words_t          words;
  psq_words_t          words_nxt;

  // Slot is free when empty or drained this cycle.
  assign in_ready = ~out_valid_r | out_ready;
  assign in_take  = in_valid & in_ready;

  psq_rules u_rules (
    .sample          (in_pin_sample),
    .last_sample     (last_sample),
    .words           (words),
    .last_sample_nxt (last_sample_nxt),
    .words_nxt       (words_nxt)
  );

  // Words only move on an accepted item, which only happens when the
  // pending result leaves, so they hold the result while it waits.
  psq_state_reg u_state (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_take),
    .last_sample_nxt (last_sample_nxt),
    .words_nxt       (words_nxt),
    .last_sample     (last_sample),
    .words           (words)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_steady_word = words.steady;
  assign out_action_word = words.action;

endmodule

/* hw/rtl/psq_checker.sv */
// Port-level checker for the panel switch qualifier, bound to the top level.
`include "panel_switch_qualifier_top_assert.svh"

module psq_port_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [psq_pkg::SAMPLE_W-1:0] in_pin_sample,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [psq_pkg::STEADY_W-1:0] out_steady_word,
  input logic [psq_pkg::ACTION_W-1:0] out_action_word
);
  import psq_pkg::*;

  // pending result holds until taken
  `PSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // nothing pending after reset
  `PSQ_ASSERT_RST(a_rst_idle, clk, !rst_n, !out_valid)
  // every accepted item gives a result next cycle
  `PSQ_ASSERT_NEXT(a_item_result, clk, rst_n, in_valid && in_ready, out_valid)
  // stop flag only comes with the enable bit clear and a cleared action word
  `PSQ_ASSERT_NOW(a_stop_clean, clk, rst_n, out_valid && out_steady_word[STOP_FLAG],
    out_action_word == '0 && out_steady_word[EN_BIT] == 1'b0)

endmodule

bind panel_switch_qualifier_top psq_port_checker u_psq_checker (.*);
